@@ hdl/iwpt_pkg.sv @@
`default_nettype none

package iwpt_pkg;

  // Moving average depth; must be a power of two (1 to 16)
  localparam int AVG_TAPS   = 4;
  localparam int TAP_SHIFT  = $clog2(AVG_TAPS);
  localparam int TAP_IDX_W  = (AVG_TAPS > 1) ? $clog2(AVG_TAPS) : 1;

  // Field widths
  localparam int ACC_W      = 16;
  localparam int GYRO_W     = 23;
  localparam int SOUND_W    = 12;
  localparam int ACC_SUM_W  = ACC_W + TAP_SHIFT;
  localparam int ACC_MAG_W  = 16;
  localparam int ACC_SQ_W   = 2 * ACC_MAG_W;
  localparam int GYRO_MAG_W = GYRO_W;
  localparam int GYRO_SQ_W  = 2 * GYRO_MAG_W;
  localparam int GYRO_OUT_W = 22;

  // Square root unit: radicand width, root width, step counter
  localparam int SQ_W       = GYRO_SQ_W;
  localparam int ROOT_W     = SQ_W / 2;
  localparam int ROOT_CNT_W = $clog2(ROOT_W + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int WLEN_W     = 8;
  localparam int GREF_W     = 14;
  localparam int MSTART_W   = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_START  = 2'd2;

  localparam logic [WLEN_W-1:0]   WLEN_RST   = 8'd25;
  localparam logic [GREF_W-1:0]   GREF_RST   = 14'd1000;
  localparam logic [MSTART_W-1:0] MSTART_RST = 16'd10102;

  // Control from the sequencer to every lane
  typedef struct packed {
    logic                 load;
    logic [TAP_IDX_W-1:0] idx;
  } lane_ctl_t;

endpackage

`default_nettype wire

@@ hdl/imu_window_peak_tracker.sv @@
// Channel   Direction  Handshake              Payload
// in_       request    in_valid / in_stall    3 accel axes, 3 gyro axes, sound level
// out_      report     out_valid / out_stall  peak and minimum trackers of a window
// cfg_      write      cfg_we                 cfg_idx, cfg_wdata
//
// From acceptance to the next acceptance a sample passes these steps: load the
// lanes, magnitude and square, start the roots, run the bit-serial square root
// units (23 root bits, one per cycle), see done, then update.
// Synchronous active-low reset clears taps, counters and peak trackers and sets the minimum tracker to its start value.
// A finished report waits in the output register; a new sample is taken
// meanwhile, and only the next report holds the update stage until it leaves.
`default_nettype none

module imu_window_peak_tracker
  import iwpt_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,

  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [ACC_W-1:0]      in_accel_x,
  input  wire logic signed [ACC_W-1:0]      in_accel_y,
  input  wire logic signed [ACC_W-1:0]      in_accel_z,
  input  wire logic signed [GYRO_W-1:0]     in_gyro_x,
  input  wire logic signed [GYRO_W-1:0]     in_gyro_y,
  input  wire logic signed [GYRO_W-1:0]     in_gyro_z,
  input  wire logic        [SOUND_W-1:0]    in_sound_level,

  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic             [SOUND_W-1:0]    out_loudest_sound,
  output logic             [ACC_MAG_W-1:0]  out_peak_accel_mg,
  output logic             [ACC_MAG_W-1:0]  out_min_accel_mg,
  output logic             [ACC_MAG_W-1:0]  out_peak_dev_mg,
  output logic             [GYRO_OUT_W-1:0] out_peak_gyro_mdps,

  input  wire logic                         cfg_we,
  input  wire logic        [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic        [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAG,
    S_SQ,
    S_ROOT,
    S_WAIT,
    S_UPD
  } state_t;

  state_t                 state_r;
  logic [WLEN_W-1:0]      wlen_r;
  logic [GREF_W-1:0]      gref_r;
  logic [MSTART_W-1:0]    mstart_r;
  logic [TAP_IDX_W-1:0]   tap_idx_r;
  logic [WLEN_W-1:0]      wcount_r;
  logic [SOUND_W-1:0]     sound_r;

  logic [SOUND_W-1:0]     max_sound_r;
  logic [ACC_MAG_W-1:0]   max_accel_r;
  logic [ACC_MAG_W-1:0]   least_accel_r;
  logic [ACC_MAG_W-1:0]   max_dev_r;
  logic [GYRO_OUT_W-1:0]  max_gyro_r;

  logic                   out_valid_r;
  logic [SOUND_W-1:0]     out_sound_r;
  logic [ACC_MAG_W-1:0]   out_accel_r;
  logic [ACC_MAG_W-1:0]   out_least_r;
  logic [ACC_MAG_W-1:0]   out_dev_r;
  logic [GYRO_OUT_W-1:0]  out_gyro_r;

  logic                   accept;
  lane_ctl_t              lane_ctl;
  logic [ACC_SQ_W-1:0]    asq_x, asq_y, asq_z;
  logic [GYRO_SQ_W-1:0]   gsq_x, gsq_y, gsq_z;
  logic [SQ_W-1:0]        acc_rad, gyro_rad;
  logic                   root_start;
  logic                   acc_done, gyro_done;
  logic [ROOT_W-1:0]      acc_root, gyro_root;

  logic [ACC_MAG_W-1:0]   amag;
  logic [GYRO_OUT_W-1:0]  gmag;
  logic [ACC_MAG_W-1:0]   dev;
  logic [SOUND_W-1:0]     upd_sound;
  logic [ACC_MAG_W-1:0]   upd_accel;
  logic [ACC_MAG_W-1:0]   upd_least;
  logic [ACC_MAG_W-1:0]   upd_dev;
  logic [GYRO_OUT_W-1:0]  upd_gyro;
  logic                   emit;
  logic                   upd_go;
  logic                   report_load;
  logic [WLEN_W-1:0]      wcount_inc;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);

  assign lane_ctl = '{load: accept, idx: tap_idx_r};

  // Accelerometer lanes: moving average, magnitude, square
  iwpt_accel_lane u_acc_x (.clk, .rst_n, .ctl(lane_ctl), .sample(in_accel_x), .sq(asq_x));
  iwpt_accel_lane u_acc_y (.clk, .rst_n, .ctl(lane_ctl), .sample(in_accel_y), .sq(asq_y));
  iwpt_accel_lane u_acc_z (.clk, .rst_n, .ctl(lane_ctl), .sample(in_accel_z), .sq(asq_z));

  // Gyro lanes: magnitude, square
  iwpt_gyro_lane u_gyr_x (.clk, .ctl(lane_ctl), .sample(in_gyro_x), .sq(gsq_x));
  iwpt_gyro_lane u_gyr_y (.clk, .ctl(lane_ctl), .sample(in_gyro_y), .sq(gsq_y));
  iwpt_gyro_lane u_gyr_z (.clk, .ctl(lane_ctl), .sample(in_gyro_z), .sq(gsq_z));

  // Merge: sum of squares per sensor into the root units
  assign acc_rad    = SQ_W'(asq_x) + SQ_W'(asq_y) + SQ_W'(asq_z);
  assign gyro_rad   = gsq_x + gsq_y + gsq_z;
  assign root_start = (state_r == S_ROOT);

  iwpt_isqrt u_acc_root (
    .clk, .rst_n, .start(root_start), .radicand(acc_rad),
    .done(acc_done), .root(acc_root)
  );

  iwpt_isqrt u_gyro_root (
    .clk, .rst_n, .start(root_start), .radicand(gyro_rad),
    .done(gyro_done), .root(gyro_root)
  );

  // Magnitudes, deviation and tracker candidates
  always_comb begin
    amag = acc_root[ACC_MAG_W-1:0];
    if (|gyro_root[ROOT_W-1:GYRO_OUT_W]) begin
      gmag = '1;
    end else begin
      gmag = gyro_root[GYRO_OUT_W-1:0];
    end
    if (amag >= ACC_MAG_W'(gref_r)) begin
      dev = amag - ACC_MAG_W'(gref_r);
    end else begin
      dev = ACC_MAG_W'(gref_r) - amag;
    end
    upd_sound   = (sound_r > max_sound_r)   ? sound_r : max_sound_r;
    upd_accel   = (amag > max_accel_r)      ? amag    : max_accel_r;
    upd_least   = (amag < least_accel_r)    ? amag    : least_accel_r;
    upd_dev     = (dev > max_dev_r)         ? dev     : max_dev_r;
    upd_gyro    = (gmag > max_gyro_r)       ? gmag    : max_gyro_r;
    emit        = (wcount_r == '0);
    upd_go      = !emit || !out_valid_r || !out_stall;
    report_load = (state_r == S_UPD) && upd_go && emit;
    wcount_inc  = wcount_r + 1'b1;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r   <= WLEN_RST;
      gref_r   <= GREF_RST;
      mstart_r <= MSTART_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_WINDOW_LEN: wlen_r   <= cfg_wdata[WLEN_W-1:0];
        REG_GRAVITY:    gref_r   <= cfg_wdata[GREF_W-1:0];
        REG_MIN_START:  mstart_r <= cfg_wdata[MSTART_W-1:0];
        default:        ;
      endcase
    end
  end

  // Sample capture (payload only)
  always_ff @(posedge clk) begin
    if (accept) begin
      sound_r <= in_sound_level;
    end
  end

  // Sequencer, trackers and report register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      tap_idx_r     <= '0;
      wcount_r      <= '0;
      max_sound_r   <= '0;
      max_accel_r   <= '0;
      least_accel_r <= MSTART_RST;
      max_dev_r     <= '0;
      max_gyro_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      // Report valid: set on an emitting update, cleared once taken
      if (report_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_MAG;
            if (tap_idx_r == TAP_IDX_W'(AVG_TAPS - 1)) begin
              tap_idx_r <= '0;
            end else begin
              tap_idx_r <= tap_idx_r + 1'b1;
            end
          end
        end
        S_MAG:  state_r <= S_SQ;
        S_SQ:   state_r <= S_ROOT;
        S_ROOT: state_r <= S_WAIT;
        S_WAIT: begin
          if (acc_done && gyro_done) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (upd_go) begin
            state_r <= S_IDLE;
            wcount_r <= (wcount_inc >= wlen_r) ? '0 : wcount_inc;
            if (emit) begin
              out_sound_r   <= upd_sound;
              out_accel_r   <= upd_accel;
              out_least_r   <= upd_least;
              out_dev_r     <= upd_dev;
              out_gyro_r    <= upd_gyro;
              max_sound_r   <= '0;
              max_accel_r   <= '0;
              least_accel_r <= mstart_r;
              max_dev_r     <= '0;
              max_gyro_r    <= '0;
            end else begin
              max_sound_r   <= upd_sound;
              max_accel_r   <= upd_accel;
              least_accel_r <= upd_least;
              max_dev_r     <= upd_dev;
              max_gyro_r    <= upd_gyro;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_loudest_sound  = out_sound_r;
  assign out_peak_accel_mg  = out_accel_r;
  assign out_min_accel_mg   = out_least_r;
  assign out_peak_dev_mg    = out_dev_r;
  assign out_peak_gyro_mdps = out_gyro_r;

endmodule

`default_nettype wire

@@ hdl/iwpt_accel_lane.sv @@
`default_nettype none

module iwpt_accel_lane
  import iwpt_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire lane_ctl_t               ctl,
  input  wire logic signed [ACC_W-1:0] sample,
  output logic         [ACC_SQ_W-1:0]  sq
);

  logic signed [ACC_W-1:0]     taps_r [AVG_TAPS];
  logic signed [ACC_SUM_W-1:0] tap_sum;
  logic signed [ACC_SUM_W-1:0] avg;
  logic        [ACC_SUM_W-1:0] avg_abs;
  logic        [ACC_MAG_W-1:0] mag_r;
  logic        [ACC_SQ_W-1:0]  sq_r;

  // Tap line: new sample overwrites the oldest entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < AVG_TAPS; k++) taps_r[k] <= '0;
    end else if (ctl.load) begin
      taps_r[ctl.idx] <= sample;
    end
  end

  // Tap sum, divided with truncation toward zero
  always_comb begin
    tap_sum = '0;
    for (int k = 0; k < AVG_TAPS; k++) begin
      tap_sum = tap_sum + ACC_SUM_W'(taps_r[k]);
    end
    if (tap_sum < 0) begin
      avg = (tap_sum + signed'(ACC_SUM_W'(AVG_TAPS - 1))) >>> TAP_SHIFT;
    end else begin
      avg = tap_sum >>> TAP_SHIFT;
    end
    avg_abs = (avg < 0) ? ACC_SUM_W'(-avg) : ACC_SUM_W'(avg);
  end

  // Magnitude then square, one register each
  always_ff @(posedge clk) begin
    mag_r <= avg_abs[ACC_MAG_W-1:0];
    sq_r  <= mag_r * mag_r;
  end

  assign sq = sq_r;

endmodule

`default_nettype wire

@@ hdl/iwpt_gyro_lane.sv @@
`default_nettype none

module iwpt_gyro_lane
  import iwpt_pkg::*;
(
  input  wire logic                     clk,
  input  wire lane_ctl_t                ctl,
  input  wire logic signed [GYRO_W-1:0] sample,
  output logic         [GYRO_SQ_W-1:0]  sq
);

  logic signed [GYRO_W-1:0]     g_r;
  logic        [GYRO_MAG_W-1:0] mag_r;
  logic        [GYRO_SQ_W-1:0]  sq_r;

  // Capture the rate, then magnitude, then square
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      g_r <= sample;
    end
    mag_r <= (g_r < 0) ? GYRO_MAG_W'(-g_r) : GYRO_MAG_W'(g_r);
    sq_r  <= mag_r * mag_r;
  end

  assign sq = sq_r;

endmodule

`default_nettype wire

@@ hdl/iwpt_isqrt.sv @@
`default_nettype none

module iwpt_isqrt
  import iwpt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [SQ_W-1:0]   radicand,
  output logic                   done,
  output logic      [ROOT_W-1:0] root
);

  logic [SQ_W-1:0]       op_r;
  logic [ROOT_W:0]       rem_r;
  logic [ROOT_W-1:0]     root_r;
  logic [ROOT_CNT_W-1:0] cnt_r;
  logic                  busy_r;
  logic                  done_r;

  logic [ROOT_W+1:0]     rem_sh;
  logic [ROOT_W+1:0]     trial;
  logic [ROOT_W+1:0]     diff;
  logic                  take;

  // One root bit per cycle: bring down two radicand bits, try 4r+1
  always_comb begin
    rem_sh = {rem_r[ROOT_W-1:0], op_r[SQ_W-1 -: 2]};
    trial  = {root_r, 2'b01};
    diff   = rem_sh - trial;
    take   = (rem_sh >= trial);
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // done pulses for one cycle after the last root bit
      done_r <= !start && busy_r && (cnt_r == ROOT_CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= ROOT_CNT_W'(ROOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == ROOT_CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      op_r   <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      op_r <= {op_r[SQ_W-3:0], 2'b00};
      if (take) begin
        rem_r  <= diff[ROOT_W:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[ROOT_W:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire
